>>> src/spn_block_encrypt32_unit_defines.svh
// Assertion macros shared by the SPN encryption unit.
`ifndef SPN_BLOCK_ENCRYPT32_UNIT_DEFINES_SVH
`define SPN_BLOCK_ENCRYPT32_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SPN_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spn assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SPN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spn assertion failed");

`endif

>>> src/spn_pkg.sv
// Package with types, constants and round functions of the SPN encryption unit.
package spn_pkg;

    localparam int BLOCK_W      = 32;
    localparam int ROUNDS       = 4;
    localparam int KEY_ROT_STEP = 11;
    localparam int ROT_W        = $clog2(BLOCK_W);

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [ROT_W-1:0]   rot_t;

    // One block travelling between neighboring cells.
    typedef struct packed {
        logic   valid;
        block_t data;
    } link_t;

    // 4-bit substitution table.
    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    // Rotation amount of the key for a given round.
    function automatic rot_t key_rot(input int r);
        int amt;
        amt = (KEY_ROT_STEP * r) % BLOCK_W;
        return rot_t'(amt);
    endfunction

    // Rotate a block left.
    function automatic block_t rol(input block_t v, input rot_t c);
        logic [2*BLOCK_W-1:0] dbl;
        dbl = {v, v} << c;
        return dbl[2*BLOCK_W-1:BLOCK_W];
    endfunction

    // Apply the S-box to every nibble.
    function automatic block_t substitute(input block_t v);
        block_t res;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            res[n*4 +: 4] = SBOX[v[n*4 +: 4]];
        end
        return res;
    endfunction

    // Bit transpose; positions count from the MSB.
    function automatic block_t transpose(input block_t v);
        block_t res;
        for (int k = 0; k < BLOCK_W; k++) begin
            res[BLOCK_W-1-k] = v[BLOCK_W-1-((k % 8) * 4 + k / 8)];
        end
        return res;
    endfunction

endpackage

>>> src/spn_round_cell.sv
// One full round cell: key mix, substitution and transpose, then a register.
module spn_round_cell
    import spn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  link_t  up,
    output logic   up_ready,
    input  block_t mix_key,
    output link_t  down,
    input  logic   down_ready
);

    logic   valid_reg;
    block_t data_reg;
    block_t data_next;

    // The cell takes a new request when empty or when its content moves on.
    assign up_ready = !valid_reg || down_ready;

    // Round function.
    assign data_next = transpose(substitute(up.data ^ mix_key));

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

>>> src/spn_last_cell.sv
// Final round cell: key mix and substitution, final whitening, output register.
module spn_last_cell
    import spn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  link_t  up,
    output logic   up_ready,
    input  block_t mix_key,
    input  block_t final_key,
    output link_t  down,
    input  logic   down_ready
);

    logic   valid_reg;
    block_t data_reg;
    block_t data_next;

    // The cell takes a new request when empty or when its content is taken.
    assign up_ready = !valid_reg || down_ready;

    // Last round without transpose, then the whitening key.
    assign data_next = substitute(up.data ^ mix_key) ^ final_key;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

>>> src/spn_block_encrypt32_unit.sv
// An accepted request passes through the round cells and then the last cell, each a register, to the output.
// Throughput: one block per cycle while out_stall is low; each round cell holds one block and hands it on.
// A stall on the output backs up through the chain of cells, one cell per block held.
// Reset clears all cell valid flags and the key register to zero.
// The key register is written through its own channel, which is always ready.
`include "spn_block_encrypt32_unit_defines.svh"

module spn_block_encrypt32_unit
    import spn_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cipher_key_valid,
    output logic   cipher_key_ready,
    input  block_t cipher_key,
    input  logic   in_valid,
    output logic   in_stall,
    input  block_t plaintext,
    output logic   out_valid,
    input  logic   out_stall,
    output block_t ciphertext
);

    block_t            cipher_key_reg;
    link_t             links [ROUNDS];
    link_t             out_link;
    logic [ROUNDS-1:0] cell_ready;
    logic [ROUNDS-1:0] cell_valid;

    // Key register.
    assign cipher_key_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= '0;
        end
        else if (cipher_key_valid && cipher_key_ready)
        begin
            cipher_key_reg <= cipher_key;
        end
    end

    // Input side of the chain.
    assign links[0].valid = in_valid;
    assign links[0].data  = plaintext;
    assign in_stall       = !cell_ready[0];

    // Full rounds.
    for (genvar g = 0; g < ROUNDS - 1; g++)
    begin : g_round
        spn_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up         (links[g]),
            .up_ready   (cell_ready[g]),
            .mix_key    (rol(cipher_key_reg, key_rot(g + 1))),
            .down       (links[g+1]),
            .down_ready (cell_ready[g+1])
        );
        assign cell_valid[g] = links[g+1].valid;
    end

    // Last round with whitening.
    spn_last_cell u_last (
        .clk        (clk),
        .rst_n      (rst_n),
        .up         (links[ROUNDS-1]),
        .up_ready   (cell_ready[ROUNDS-1]),
        .mix_key    (rol(cipher_key_reg, key_rot(ROUNDS))),
        .final_key  (rol(cipher_key_reg, key_rot(ROUNDS + 1))),
        .down       (out_link),
        .down_ready (!out_stall)
    );
    assign cell_valid[ROUNDS-1] = out_link.valid;

    assign out_valid  = out_link.valid;
    assign ciphertext = out_link.data;

    // Input stalls only when every cell is full and the output is stalled.
    `SPN_ASSERT_NOW(a_stall_only_full, in_stall, out_stall && (&cell_valid))
    // An idle chain never stalls the input.
    `SPN_ASSERT_NOW(a_empty_no_stall, cell_valid == '0, !in_stall)
    // A result disappears only after it was taken.
    `SPN_ASSERT_NEXT(a_out_taken, out_valid && out_stall, out_valid)
    // An accepted request reaches the first cell.
    `SPN_ASSERT_NEXT(a_first_cell_loaded, in_valid && !in_stall, cell_valid[0])

endmodule

>>> dv/tb_spn_block_encrypt32_unit.sv
// Self-checking testbench for the 32-bit SPN block encryption unit.
module tb_spn_block_encrypt32_unit
    import spn_pkg::*;
();

    // Keeps the running key and the ciphertexts still owed by the unit.
    class ciphertext_tracker;
        block_t     active_key;
        block_t     owed_ciphertexts[$];
        int         blocks_checked;
        int         mismatches;
        logic [3:0] nibble_map[16];

        function new();
            nibble_map = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
                           4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};
            active_key     = '0;
            blocks_checked = 0;
            mismatches     = 0;
        endfunction

        // The round key is the master key rotated left by 11*r mod 32.
        function block_t key_for_round(input int r);
            int amt;
            amt = (KEY_ROT_STEP * r) % BLOCK_W;
            if (amt == 0)
                return active_key;
            return (active_key << amt) | (active_key >> (BLOCK_W - amt));
        endfunction

        function block_t sub_nibbles(input block_t v);
            block_t res;
            for (int n = 0; n < BLOCK_W / 4; n++)
                res[n*4 +: 4] = nibble_map[v[n*4 +: 4]];
            return res;
        endfunction

        // Position k counted from the MSB takes position (k mod 8)*4 + k/8.
        function block_t shuffle_bits(input block_t v);
            block_t res;
            int     src;
            for (int k = 0; k < BLOCK_W; k++) begin
                src = (k % 8) * 4 + k / 8;
                res[BLOCK_W-1-k] = v[BLOCK_W-1-src];
            end
            return res;
        endfunction

        function block_t encipher(input block_t pt);
            block_t m;
            m = pt;
            for (int r = 1; r < ROUNDS; r++)
                m = shuffle_bits(sub_nibbles(m ^ key_for_round(r)));
            m = sub_nibbles(m ^ key_for_round(ROUNDS));
            return m ^ key_for_round(ROUNDS + 1);
        endfunction

        function void load_key(input block_t k);
            active_key = k;
        endfunction

        function void note_plaintext(input block_t pt);
            owed_ciphertexts.insert(owed_ciphertexts.size(), encipher(pt));
        endfunction

        function void check_ciphertext(input block_t ct);
            block_t want;
            if (owed_ciphertexts.size() == 0) begin
                $display("%0t: unexpected ciphertext %h with nothing owed", $time, ct);
                mismatches++;
            end else begin
                want = owed_ciphertexts.pop_front();
                blocks_checked++;
                if (want !== ct) begin
                    $display("%0t: ciphertext mismatch, expected %h, actual %h",
                             $time, want, ct);
                    mismatches++;
                end
            end
        endfunction

        function int owed();
            return owed_ciphertexts.size();
        endfunction
    endclass

    logic   clk              = 1'b0;
    logic   rst_n            = 1'b0;
    logic   cipher_key_valid = 1'b0;
    logic   cipher_key_ready;
    block_t cipher_key       = '0;
    logic   in_valid         = 1'b0;
    logic   in_stall;
    block_t plaintext        = '0;
    logic   out_valid;
    logic   out_stall        = 1'b0;
    block_t ciphertext;

    int idle_pct  = 0;
    int stall_pct = 0;
    int key_writes = 0;

    ciphertext_tracker tracker = new();

    spn_block_encrypt32_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cipher_key_valid (cipher_key_valid),
        .cipher_key_ready (cipher_key_ready),
        .cipher_key       (cipher_key),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .plaintext        (plaintext),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .ciphertext       (ciphertext)
    );

    always #1 clk = ~clk;

    // Random back-pressure on the result side.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watch all three channels and feed the tracker.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cipher_key_valid && cipher_key_ready)
                tracker.load_key(cipher_key);
            if (in_valid && !in_stall)
                tracker.note_plaintext(plaintext);
            if (out_valid && !out_stall)
                tracker.check_ciphertext(ciphertext);
        end
    end

    // Present one request, with random idle cycles ahead of it.
    task automatic send_block(input block_t pt);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        plaintext <= pt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every owed ciphertext has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.owed() != 0);
    endtask

    task automatic write_key(input block_t k);
        cipher_key_valid <= 1'b1;
        cipher_key       <= k;
        @(posedge clk);
        while (!cipher_key_ready)
            @(posedge clk);
        cipher_key_valid <= 1'b0;
        key_writes++;
    endtask

    // Mostly full-range values, with sparse and dense patterns mixed in.
    function automatic block_t pick_plaintext();
        block_t v;
        case ($urandom_range(7))
            0:       v = block_t'(1) << $urandom_range(31);
            1:       v = ~(block_t'(1) << $urandom_range(31));
            2:       v = block_t'(4'hF) << (4 * $urandom_range(7));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    block_t edge_blocks[20] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h0000_000F, 32'hF000_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        32'hAAAA_AAAA, 32'h5555_5555, 32'h0123_4567, 32'h89AB_CDEF,
        32'hFEDC_BA98, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h1111_1111,
        32'hEEEE_EEEE, 32'h0001_0000, 32'h1357_9BDF, 32'hC56B_90AD
    };

    block_t phase_keys[8];

    // Main sequence: directed blocks under the reset key, then random phases.
    initial
    begin
        phase_keys = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
                       $urandom, $urandom, $urandom, $urandom};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_blocks[i])
            send_block(edge_blocks[i]);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_key(phase_keys[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (94)
                send_block(pick_plaintext());
            drain();
        end

        // Let the pipeline settle to catch any stray result.
        stall_pct = 0;
        repeat (ROUNDS + 8) @(posedge clk);

        $display("Encrypted %0d blocks under %0d key writes plus the reset key,",
                 tracker.blocks_checked, key_writes);
        $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
        if (tracker.owed() != 0) begin
            $display("%0t: %0d ciphertexts never arrived", $time, tracker.owed());
            tracker.mismatches++;
        end
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
